// ===== src/dfu_pc_pkg.sv =====
`default_nettype none

package dfu_pc_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRC_ENABLE   = 1'b1;

    // Header layout of a packet.
    localparam logic [7:0] HEADER_BYTES = 8'd4;
    localparam logic [7:0] SEQ_POS      = 8'd0;
    localparam logic [7:0] FLAG_POS     = 8'd1;
    localparam logic [7:0] LEN_POS      = 8'd2;
    localparam logic [7:0] FLAG_MASK    = 8'h07;

    // CRC-8 and sequence constants.
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] CRC_INIT     = 8'h00;
    localparam logic [7:0] SEQ_NONE     = 8'hFF;
    localparam logic [7:0] POS_MAX      = 8'hFF;

    typedef enum logic [2:0] {
        PT_IDLE      = 3'd0,
        PT_START     = 3'd1,
        PT_CONT      = 3'd2,
        PT_END       = 3'd3,
        PT_CONT_LAST = 3'd4
    } t_pkt_type;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SEQ   = 3'd1,
        ST_HDR   = 3'd2,
        ST_CRC   = 3'd3,
        ST_WRITE = 3'd4
    } t_status;

    // Request from the front part to the back part: a session start or a packet end.
    typedef struct packed {
        logic       is_start;
        logic [7:0] seq;
        logic [7:0] flag;
        logic [7:0] len;
        logic       crc_ok;
        logic       wfail;
    } t_evt;

    // One acknowledgement.
    typedef struct packed {
        t_status     status;
        logic [7:0]  seq;
        logic        active;
        logic        switch_ok;
        logic [31:0] left;
    } t_ack;

    typedef struct packed {
        logic      legal;
        t_pkt_type nxt;
    } t_trans;

    // One CRC-8 step over a whole byte, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Legal packet type transitions.
    function automatic t_trans next_type(input t_pkt_type cur, input logic [7:0] flag);
        t_trans t;
        t.legal = 1'b0;
        t.nxt   = PT_IDLE;
        priority if (cur == PT_IDLE &&
                     (flag == {5'd0, PT_START} || flag == {5'd0, PT_END})) begin
            t.legal = 1'b1;
        end else if (cur == PT_START &&
                     (flag == {5'd0, PT_CONT} || flag == {5'd0, PT_END})) begin
            t.legal = 1'b1;
        end else if (cur == PT_CONT &&
                     (flag == {5'd0, PT_CONT} || flag == {5'd0, PT_CONT_LAST})) begin
            t.legal = 1'b1;
        end else begin
            t.legal = 1'b0;
        end
        if (t.legal) begin
            t.nxt = t_pkt_type'(flag[2:0]);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== src/dfu_pc_fifo.sv =====
`default_nettype none

module dfu_pc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count did not follow a lone write");

endmodule

`default_nettype wire

// ===== src/dfu_pc_front.sv =====
`default_nettype none

module dfu_pc_front
    import dfu_pc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_packet_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_write_failed,
    output logic            o_evt_push,
    output t_evt            o_evt
);

    logic [7:0] r_crc, n_crc;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_hdr_seq, n_hdr_seq;
    logic [7:0] r_hdr_flag, n_hdr_flag;
    logic [7:0] r_hdr_len, n_hdr_len;
    logic [7:0] w_seq, w_flag, w_len;
    logic       w_in_hdr;

    // Header capture including the byte now arriving.
    always_comb begin
        w_in_hdr = (r_pos < HEADER_BYTES);
        w_seq    = (w_in_hdr && r_pos == SEQ_POS)  ? i_packet_byte : r_hdr_seq;
        w_flag   = (w_in_hdr && r_pos == FLAG_POS) ? i_packet_byte : r_hdr_flag;
        w_len    = (w_in_hdr && r_pos == LEN_POS)  ? i_packet_byte : r_hdr_len;
    end

    // Packet state: running CRC, byte position and header fields.
    always_comb begin
        n_crc      = r_crc;
        n_pos      = r_pos;
        n_hdr_seq  = r_hdr_seq;
        n_hdr_flag = r_hdr_flag;
        n_hdr_len  = r_hdr_len;
        o_evt_push = 1'b0;
        o_evt.is_start = !i_opcode;
        o_evt.seq      = w_seq;
        o_evt.flag     = w_flag;
        o_evt.len      = w_len;
        o_evt.crc_ok   = (r_crc == i_packet_byte);
        o_evt.wfail    = i_write_failed;
        if (i_accept) begin
            if (!i_opcode || i_last_byte) begin
                // Session start or packet end: hand over and clear the packet.
                o_evt_push = 1'b1;
                n_crc      = CRC_INIT;
                n_pos      = '0;
                n_hdr_seq  = '0;
                n_hdr_flag = '0;
                n_hdr_len  = '0;
            end else begin
                n_crc      = crc8_byte(r_crc, i_packet_byte);
                n_pos      = (r_pos == POS_MAX) ? r_pos : r_pos + 8'd1;
                n_hdr_seq  = w_seq;
                n_hdr_flag = w_flag;
                n_hdr_len  = w_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_pos      <= '0;
            r_hdr_seq  <= '0;
            r_hdr_flag <= '0;
            r_hdr_len  <= '0;
        end else begin
            r_crc      <= n_crc;
            r_pos      <= n_pos;
            r_hdr_seq  <= n_hdr_seq;
            r_hdr_flag <= n_hdr_flag;
            r_hdr_len  <= n_hdr_len;
        end
    end

endmodule

`default_nettype wire

// ===== src/dfu_pc_back.sv =====
`default_nettype none

module dfu_pc_back
    import dfu_pc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [31:0]           i_cfg_wdata,
    input  wire logic                  i_evt_valid,
    input  wire t_evt                  i_evt,
    output logic                       o_evt_pop,
    input  wire logic                  i_res_full,
    output logic                       o_res_push,
    output t_ack                       o_res
);

    logic [31:0] r_total_length;
    logic        r_crc_enable;

    logic        r_active, n_active;
    logic        r_switch_ok, n_switch_ok;
    logic [7:0]  r_last_seq, n_last_seq;
    t_pkt_type   r_ptype, n_ptype;
    logic [31:0] r_remaining, n_remaining;

    t_trans      w_trans;
    t_status     w_status;
    logic [7:0]  w_dlen;
    logic [31:0] w_rem_next;
    logic        w_done;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= '0;
            r_crc_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TOTAL_LENGTH: r_total_length <= i_cfg_wdata;
                CFG_CRC_ENABLE:   r_crc_enable   <= i_cfg_wdata[0];
            endcase
        end
    end

    // Packet checks in priority order.
    always_comb begin
        w_trans = next_type(r_ptype, i_evt.flag & FLAG_MASK);
        priority if (i_evt.seq != r_last_seq + 8'd1) begin
            w_status = ST_SEQ;
        end else if (!w_trans.legal) begin
            w_status = ST_HDR;
        end else if (r_crc_enable && i_evt.len == 8'd0) begin
            w_status = ST_HDR;
        end else if (r_crc_enable && !i_evt.crc_ok) begin
            w_status = ST_CRC;
        end else if (i_evt.wfail) begin
            w_status = ST_WRITE;
        end else begin
            w_status = ST_OK;
        end
        w_dlen     = r_crc_enable ? i_evt.len - 8'd1 : i_evt.len;
        w_rem_next = (r_remaining > {24'd0, w_dlen}) ? r_remaining - {24'd0, w_dlen} : '0;
        w_done     = (w_trans.nxt == PT_END) || (w_trans.nxt == PT_CONT_LAST) ||
                     (w_rem_next == '0);
    end

    // Session state update and acknowledgement.
    always_comb begin
        n_active    = r_active;
        n_switch_ok = r_switch_ok;
        n_last_seq  = r_last_seq;
        n_ptype     = r_ptype;
        n_remaining = r_remaining;
        o_evt_pop   = i_evt_valid && !i_res_full;
        o_res_push  = 1'b0;
        if (o_evt_pop) begin
            if (i_evt.is_start) begin
                n_active    = 1'b1;
                n_switch_ok = 1'b0;
                n_last_seq  = SEQ_NONE;
                n_ptype     = PT_IDLE;
                n_remaining = r_total_length;
            end else if (r_active) begin
                o_res_push = 1'b1;
                if (w_status != ST_OK) begin
                    n_active    = 1'b0;
                    n_switch_ok = 1'b0;
                    n_last_seq  = SEQ_NONE;
                    n_ptype     = PT_IDLE;
                end else begin
                    n_remaining = w_rem_next;
                    if (w_done) begin
                        n_active    = 1'b0;
                        n_switch_ok = 1'b1;
                        n_last_seq  = SEQ_NONE;
                        n_ptype     = PT_IDLE;
                    end else begin
                        n_last_seq  = i_evt.seq;
                        n_ptype     = w_trans.nxt;
                    end
                end
            end
        end
        o_res.status    = w_status;
        o_res.seq       = i_evt.seq;
        o_res.active    = n_active;
        o_res.switch_ok = n_switch_ok;
        o_res.left      = n_remaining;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_switch_ok <= 1'b0;
            r_last_seq  <= SEQ_NONE;
            r_ptype     <= PT_IDLE;
            r_remaining <= '0;
        end else begin
            r_active    <= n_active;
            r_switch_ok <= n_switch_ok;
            r_last_seq  <= n_last_seq;
            r_ptype     <= n_ptype;
            r_remaining <= n_remaining;
        end
    end

    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_ptype == PT_IDLE && r_last_seq == SEQ_NONE))
        else $error("closed session left packet type or sequence behind");

    a_switch_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_switch_ok |-> !r_active)
        else $error("bank switch allowed while a session is open");

    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && w_status != ST_OK) |=> (!r_active && !r_switch_ok))
        else $error("failed packet did not close the session");

endmodule

`default_nettype wire

// ===== src/dfu_packet_checker_unit.sv =====
// Firmware update packet checker.
// Input queue: present opcode, packet_byte, last_byte and write_failed with
// push; a request is taken at a clock edge with push high and full low. A
// start opcode opens a session; packet bytes follow one per request, and in
// an open session the request with last_byte produces one acknowledgement.
// Result queue: while empty is low the oldest acknowledgement (status,
// sequence, session state, bank switch permission, bytes left) is on the
// o_ ports; pop with empty low takes it.
// Configuration: i_cfg_we writes i_cfg_wdata to total_length (index 0) or
// crc_enable (index 1) at that edge; write only while the block is idle.
// Throughput is one request per cycle while full is low. A front stage
// keeps the running CRC-8 and the header capture, a back stage holds the
// session state and checks each finished packet. An acknowledgement passes
// through the request queue and then the result queue to the result ports.
// When the result queue fills, the back stage stops and the request queue
// between the stages fills behind it; full then rises until pop frees space.
// Reset clears both queues, the session (closed) and the configuration.
`default_nettype none

module dfu_packet_checker_unit
    import dfu_pc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH  = 4,
    parameter int unsigned RESULT_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [31:0]           i_cfg_wdata,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_opcode,
    input  wire logic [7:0]            i_packet_byte,
    input  wire logic                  i_last_byte,
    input  wire logic                  i_write_failed,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [2:0]                 o_ack_status,
    output logic [7:0]                 o_ack_sequence,
    output logic                       o_session_active,
    output logic                       o_bank_switch_allowed,
    output logic [31:0]                o_bytes_left
);

    logic w_accept;
    logic w_evt_push;
    t_evt w_evt_in;
    t_evt w_evt_out;
    logic w_evt_empty;
    logic w_evt_pop;
    logic w_res_push;
    logic w_res_full;
    t_ack w_res_in;
    t_ack w_res_out;

    assign w_accept = push && !full;

    // Front stage: packet bytes, CRC and header capture.
    dfu_pc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_opcode       (i_opcode),
        .i_packet_byte  (i_packet_byte),
        .i_last_byte    (i_last_byte),
        .i_write_failed (i_write_failed),
        .o_evt_push     (w_evt_push),
        .o_evt          (w_evt_in)
    );

    // Request queue between the stages.
    dfu_pc_fifo #(
        .WIDTH ($bits(t_evt)),
        .DEPTH (QUEUE_DEPTH)
    ) u_evt_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_evt_push),
        .i_data  (w_evt_in),
        .o_full  (full),
        .i_pop   (w_evt_pop),
        .o_data  (w_evt_out),
        .o_empty (w_evt_empty)
    );

    // Back stage: session checks and acknowledgements.
    dfu_pc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt_valid (!w_evt_empty),
        .i_evt       (w_evt_out),
        .o_evt_pop   (w_evt_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // Result queue toward the receiver.
    dfu_pc_fifo #(
        .WIDTH ($bits(t_ack)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_ack_status          = w_res_out.status;
    assign o_ack_sequence        = w_res_out.seq;
    assign o_session_active      = w_res_out.active;
    assign o_bank_switch_allowed = w_res_out.switch_ok;
    assign o_bytes_left          = w_res_out.left;

endmodule

`default_nettype wire

// ===== tb/dfu_packet_checker_unit_test.sv =====
module dfu_packet_checker_unit_test;
    import dfu_pc_pkg::*;

    // Opcodes of an input request.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    localparam int RANDOM_ITEMS   = 220;
    localparam int PHASE_ITEMS    = 55;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = CFG_TOTAL_LENGTH;
    logic [31:0]           i_cfg_wdata = 32'd0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_opcode = OP_START;
    logic [7:0]            i_packet_byte = 8'd0;
    logic                  i_last_byte = 1'b0;
    logic                  i_write_failed = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [2:0]            o_ack_status;
    logic [7:0]            o_ack_sequence;
    logic                  o_session_active;
    logic                  o_bank_switch_allowed;
    logic [31:0]           o_bytes_left;

    dfu_packet_checker_unit dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_addr            (i_cfg_addr),
        .i_cfg_wdata           (i_cfg_wdata),
        .push                  (push),
        .full                  (full),
        .i_opcode              (i_opcode),
        .i_packet_byte         (i_packet_byte),
        .i_last_byte           (i_last_byte),
        .i_write_failed        (i_write_failed),
        .empty                 (empty),
        .pop                   (pop),
        .o_ack_status          (o_ack_status),
        .o_ack_sequence        (o_ack_sequence),
        .o_session_active      (o_session_active),
        .o_bank_switch_allowed (o_bank_switch_allowed),
        .o_bytes_left          (o_bytes_left)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Configuration as last written, and the session state it drives.
    logic [31:0] cfg_total = 32'd0;
    logic        cfg_crc = 1'b0;
    logic        sess_active = 1'b0;
    logic        sess_switch = 1'b0;
    logic [7:0]  sess_last_seq = SEQ_NONE;
    t_pkt_type   sess_type = PT_IDLE;
    logic [31:0] sess_remaining = 32'd0;
    logic [7:0]  pkt_crc = CRC_INIT;
    logic [7:0]  pkt_pos = 8'd0;
    logic [7:0]  hdr_seq = 8'd0;
    logic [7:0]  hdr_flag = 8'd0;
    logic [7:0]  hdr_len = 8'd0;

    t_ack        pending_acks[$];
    logic [7:0]  pkt_buf[$];

    bit rst_done = 1'b0;
    bit push_stall = 1'b1;
    bit pop_stall = 1'b1;
    int fail_count = 0;
    int accepted_items = 0;
    int live_items = 0;
    int acks_checked = 0;
    int settings_used = 0;
    int idle_cycles = 0;

    // CRC-8, polynomial 0x07, one data bit at a time, MSB first.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb  = crc[7] ^ data[k];
            crc = {crc[6:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endfunction

    task automatic clear_packet_state();
        pkt_crc  = CRC_INIT;
        pkt_pos  = 8'd0;
        hdr_seq  = 8'd0;
        hdr_flag = 8'd0;
        hdr_len  = 8'd0;
    endtask

    task automatic close_session(input logic clean);
        sess_active   = 1'b0;
        sess_switch   = clean;
        sess_last_seq = SEQ_NONE;
        sess_type     = PT_IDLE;
    endtask

    // Updates the session copy for one accepted request and queues the
    // acknowledgement that a packet end produces.
    task automatic predict_ack(input logic op, input logic [7:0] b, input logic last,
                               input logic wfail);
        t_ack        ack;
        logic [7:0]  next_seq;
        logic [7:0]  flag;
        logic        legal;
        logic [31:0] used;
        if (op == OP_START) begin
            live_items++;
            sess_remaining = cfg_total;
            sess_active    = 1'b1;
            sess_switch    = 1'b0;
            sess_last_seq  = SEQ_NONE;
            sess_type      = PT_IDLE;
            clear_packet_state();
            return;
        end
        if (!sess_active) begin
            return;
        end
        live_items++;

        // Header capture, the final byte included.
        if (pkt_pos < HEADER_BYTES) begin
            if (pkt_pos == SEQ_POS) hdr_seq = b;
            if (pkt_pos == FLAG_POS) hdr_flag = b;
            if (pkt_pos == LEN_POS) hdr_len = b;
        end
        if (!last) begin
            pkt_crc = crc8_next(pkt_crc, b);
            if (pkt_pos != POS_MAX) begin
                pkt_pos = pkt_pos + 8'd1;
            end
            return;
        end

        // Packet end: checks in priority order.
        ack.status = ST_OK;
        ack.seq    = hdr_seq;
        next_seq   = sess_last_seq + 8'd1;
        if (hdr_seq != next_seq) begin
            ack.status = ST_SEQ;
        end else begin
            sess_last_seq = hdr_seq;
            flag = hdr_flag & FLAG_MASK;
            case (sess_type)
                PT_IDLE:  legal = (flag == 8'(PT_START)) || (flag == 8'(PT_END));
                PT_START: legal = (flag == 8'(PT_CONT)) || (flag == 8'(PT_END));
                PT_CONT:  legal = (flag == 8'(PT_CONT)) || (flag == 8'(PT_CONT_LAST));
                default:  legal = 1'b0;
            endcase
            if (!legal) begin
                ack.status = ST_HDR;
            end else begin
                sess_type = t_pkt_type'(flag[2:0]);
                if (cfg_crc && hdr_len == 8'd0) begin
                    ack.status = ST_HDR;
                end else if (cfg_crc && pkt_crc != b) begin
                    ack.status = ST_CRC;
                end else if (wfail) begin
                    ack.status = ST_WRITE;
                end
            end
        end

        if (ack.status != ST_OK) begin
            close_session(1'b0);
        end else begin
            used = {24'd0, hdr_len} - (cfg_crc ? 32'd1 : 32'd0);
            sess_remaining = (sess_remaining > used) ? sess_remaining - used : 32'd0;
            if (sess_type == PT_END || sess_type == PT_CONT_LAST || sess_remaining == 32'd0) begin
                close_session(1'b1);
            end
        end
        clear_packet_state();

        ack.active    = sess_active;
        ack.switch_ok = sess_switch;
        ack.left      = sess_remaining;
        pending_acks.push_back(ack);
    endtask

    // Sends one request after a random gap and waits until it is taken.
    task automatic send_req(input logic op, input logic [7:0] b, input logic last,
                            input logic wfail);
        int gap;
        gap = push_stall ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push           <= 1'b1;
        i_opcode       <= op;
        i_packet_byte  <= b;
        i_last_byte    <= last;
        i_write_failed <= wfail;
        do @(posedge i_clk); while (full !== 1'b0);
        accepted_items++;
        predict_ack(op, b, last, wfail);
    endtask

    task automatic start_session();
        send_req(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Builds a packet: sequence, flag, length, one spare header byte, payload,
    // then a CRC byte (or a plain data byte with CRC off).
    task automatic make_packet(input logic [7:0] seq, input logic [7:0] flag_byte,
                               input logic [7:0] len, input int npay, input logic crc_bad);
        logic [7:0] crc;
        pkt_buf.delete();
        pkt_buf.push_back(seq);
        pkt_buf.push_back(flag_byte);
        pkt_buf.push_back(len);
        pkt_buf.push_back(8'($urandom));
        for (int k = 0; k < npay; k++) begin
            pkt_buf.push_back(8'($urandom));
        end
        crc = CRC_INIT;
        foreach (pkt_buf[k]) begin
            crc = crc8_next(crc, pkt_buf[k]);
        end
        if (cfg_crc) begin
            pkt_buf.push_back(crc_bad ? crc ^ 8'($urandom_range(1, 255)) : crc);
        end else begin
            pkt_buf.push_back(8'($urandom));
        end
    endtask

    task automatic send_packet(input logic wfail);
        int n;
        n = pkt_buf.size();
        foreach (pkt_buf[k]) begin
            send_req(OP_BYTE, pkt_buf[k], k == n - 1, (k == n - 1) ? wfail : 1'($urandom));
        end
    endtask

    // Lets the block drain before a register write or the end of the run.
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_acks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] total, input logic crc_on);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TOTAL_LENGTH;
        i_cfg_wdata <= total;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_CRC_ENABLE;
        i_cfg_wdata <= {31'd0, crc_on};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_total = total;
        cfg_crc   = crc_on;
        settings_used++;
    endtask

    // Bytes with no open session, a packet end among them, are dropped.
    task automatic test_bytes_outside_session();
        send_req(OP_BYTE, 8'h00, 1'b0, 1'b0);
        send_req(OP_BYTE, 8'hFF, 1'b1, 1'b1);
    endtask

    // A clean start, cont, closing cont transfer with CRC; upper flag bits masked.
    task automatic test_clean_session();
        wait_idle();
        set_config(32'd10, 1'b1);
        send_req(OP_START, 8'hFF, 1'b1, 1'b1);
        make_packet(8'd0, 8'h01, 8'd1, 0, 1'b0);
        send_packet(1'b0);
        make_packet(8'd1, 8'hFA, 8'd3, 1, 1'b0);
        send_packet(1'b0);
        make_packet(8'd2, 8'h04, 8'hFF, 0, 1'b0);
        send_packet(1'b0);
    endtask

    // Each packet but the last carries several faults; only the first in check order counts.
    task automatic test_check_order();
        wait_idle();
        set_config(32'hFFFF_FFFF, 1'b1);
        start_session();
        make_packet(8'd1, 8'h02, 8'd4, 0, 1'b1);
        send_packet(1'b1);
        start_session();
        make_packet(8'd0, 8'(PT_CONT), 8'd4, 0, 1'b1);
        send_packet(1'b1);
        start_session();
        make_packet(8'd0, 8'(PT_START), 8'd0, 0, 1'b1);
        send_packet(1'b1);
        start_session();
        make_packet(8'd0, 8'(PT_START), 8'd4, 0, 1'b1);
        send_packet(1'b1);
        start_session();
        make_packet(8'd0, 8'(PT_START), 8'd4, 0, 1'b0);
        send_packet(1'b1);
    endtask

    // A restart drops the partial packet; short packets see unread header
    // fields as zero.
    task automatic test_restart_and_short_packets();
        wait_idle();
        set_config(32'hFFFF_FFFF, 1'b0);
        start_session();
        send_req(OP_BYTE, 8'h05, 1'b0, 1'b1);
        send_req(OP_BYTE, 8'h03, 1'b0, 1'b0);
        start_session();
        send_req(OP_BYTE, 8'h00, 1'b0, 1'b0);
        send_req(OP_BYTE, 8'(PT_START), 1'b1, 1'b0);
        send_req(OP_BYTE, 8'h01, 1'b1, 1'b0);
    endtask

    // An empty image: the first clean packet closes the session.
    task automatic test_empty_image();
        wait_idle();
        set_config(32'd0, 1'b0);
        start_session();
        make_packet(8'd0, 8'(PT_START), 8'd9, 1, 1'b0);
        send_packet(1'b0);
        send_req(OP_BYTE, 8'h00, 1'b1, 1'b0);
    endtask

    // A packet longer than the byte counter can hold.
    task automatic test_long_packet();
        wait_idle();
        set_config(32'd1000, 1'b1);
        start_session();
        make_packet(8'd0, 8'(PT_END), 8'd200, 256, 1'b0);
        send_packet(1'b0);
    endtask

    // One session of well-formed packets with an occasional fault.
    task automatic run_session();
        int npk;
        int fault;
        int cut;
        logic [2:0] flag;
        logic [7:0] seq;
        logic [7:0] flag_byte;
        logic [7:0] len;
        start_session();
        npk = $urandom_range(1, 5);
        for (int p = 0; p < npk && sess_active; p++) begin
            if (npk == 1) flag = PT_END;
            else if (p == 0) flag = PT_START;
            else if (npk == 2) flag = PT_END;
            else if (p == npk - 1) flag = PT_CONT_LAST;
            else flag = PT_CONT;
            fault = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;

            seq = 8'(p);
            if (fault == 1) seq = seq + 8'($urandom_range(1, 255));
            flag_byte = {5'($urandom), flag};
            if ($urandom_range(0, 1) == 0) flag_byte[7:3] = 5'd0;
            if (fault == 2) flag_byte = 8'($urandom);
            len = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
            if (fault == 3) len = 8'd0;
            make_packet(seq, flag_byte, len, $urandom_range(0, 6), fault == 4);

            if (fault == 6) begin
                // Truncated packet.
                cut = $urandom_range(1, 3);
                while (pkt_buf.size() > cut) void'(pkt_buf.pop_back());
            end
            if (fault == 7) begin
                // Restart in the middle of a packet, then one single packet.
                cut = $urandom_range(1, pkt_buf.size() - 1);
                for (int k = 0; k < cut; k++) begin
                    send_req(OP_BYTE, pkt_buf[k], 1'b0, 1'($urandom));
                end
                start_session();
                npk = 1;
                p = -1;
            end else begin
                send_packet(fault == 5);
            end
        end
        // Stray bytes after the session has closed.
        if (!sess_active) begin
            repeat ($urandom_range(0, 2)) begin
                send_req(OP_BYTE, 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        int base;
        int phase;
        int phase_end;
        logic [31:0] total;
        base  = live_items;
        phase = 0;
        while (live_items - base < RANDOM_ITEMS) begin
            wait_idle();
            case (phase % 4)
                0: total = 32'($urandom_range(0, 60));
                1: total = 32'hFFFF_FFFF;
                2: total = $urandom;
                default: total = 32'd0;
            endcase
            set_config(total, (phase % 4 == 1) ? 1'b0 : 1'($urandom));
            push_stall = ($urandom_range(0, 3) != 0);
            pop_stall  = ($urandom_range(0, 3) != 0);
            phase_end  = live_items + PHASE_ITEMS;
            while (live_items < phase_end && live_items - base < RANDOM_ITEMS) begin
                run_session();
            end
            phase++;
        end
    endtask

    // Result side: random pop gaps, each acknowledgement checked on acceptance.
    initial begin : ack_drain
        int   hold;
        t_ack want;
        hold = 0;
        wait (rst_done);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
                if (empty === 1'b0) begin
                    acks_checked++;
                    if (pending_acks.size() == 0) begin
                        note_failure($sformatf("unexpected ack: status %0d seq %0d",
                                               o_ack_status, o_ack_sequence));
                    end else begin
                        want = pending_acks.pop_front();
                        if (o_ack_status !== want.status)
                            note_failure($sformatf("ack %0d status exp %0d got %0d",
                                                   acks_checked, want.status, o_ack_status));
                        if (o_ack_sequence !== want.seq)
                            note_failure($sformatf("ack %0d sequence exp %0d got %0d",
                                                   acks_checked, want.seq, o_ack_sequence));
                        if (o_session_active !== want.active)
                            note_failure($sformatf("ack %0d session_active exp %0b got %0b",
                                                   acks_checked, want.active, o_session_active));
                        if (o_bank_switch_allowed !== want.switch_ok)
                            note_failure($sformatf("ack %0d bank_switch exp %0b got %0b",
                                                   acks_checked, want.switch_ok,
                                                   o_bank_switch_allowed));
                        if (o_bytes_left !== want.left)
                            note_failure($sformatf("ack %0d bytes_left exp %0d got %0d",
                                                   acks_checked, want.left, o_bytes_left));
                    end
                    hold = pop_stall ? $urandom_range(0, 5) : 0;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no progress, %0d acks outstanding",
                         $realtime, pending_acks.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        test_bytes_outside_session();
        test_clean_session();
        test_check_order();
        test_restart_and_short_packets();
        test_empty_image();
        test_long_packet();
        test_random_traffic();

        wait_idle();
        fail_count += pending_acks.size();
        $display("Sent %0d requests (%0d inside sessions), checked %0d acks",
                 accepted_items, live_items, acks_checked);
        $display("over %0d configuration settings; %0d mismatches.",
                 settings_used, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
